### hw/rtl/exhaustive_knn_search_unit_defines.svh
// assertion macros shared by the knn search unit
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef EXHAUSTIVE_KNN_SEARCH_UNIT_DEFINES_SVH
`define EXHAUSTIVE_KNN_SEARCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// condition must hold on every clock outside reset
`define EKNN_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");
// antecedent implies consequent in the same cycle
`define EKNN_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
// condition checked on every clock, reset included
`define EKNN_ASSERT_RAW(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("check violated");
`else
`define EKNN_ASSERT_ALWAYS(label, clk, rst, cond)
`define EKNN_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define EKNN_ASSERT_RAW(label, clk, ante, cons)
`endif
`endif

### hw/rtl/eknn_pkg.sv
// types and constants of the knn search unit
// no dependencies
`timescale 1ns / 1ps
package eknn_pkg;

   localparam int COORD_BITS  = 16;
   localparam int CMD_W       = 2;
   localparam int COMP_W      = 7;
   localparam int STATUS_W    = 2;
   localparam int RANK_W      = 4;
   localparam int INDEX_W     = 8;
   localparam int DIST_W      = 20;
   localparam int ENTRY_MAX_W = 16;
   localparam int COUNT_MAX_W = 17;

   // commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_NEIGHBOUR = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INS_OK    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   // register indexes and reset values
   localparam logic REG_DIMS  = 1'b0;
   localparam logic REG_NEIGH = 1'b1;
   localparam logic [7:0] DIMS_RESET  = 8'd128;
   localparam logic [4:0] NEIGH_RESET = 5'd10;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_INS_OK,
      ACT_INS_FULL,
      ACT_QUERY,
      ACT_QRY_EMPTY
   } action_type;

   typedef struct packed {
      logic [CMD_W-1:0]             command;
      logic [COMP_W-1:0]            component;
      logic signed [COORD_BITS-1:0] coordinate;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RANK_W-1:0]   rank;
      logic [INDEX_W-1:0]  entry_index;
      logic [DIST_W-1:0]   distance;
      logic                last;
   } rsp_type;

   // one operation from the front to the back
   typedef struct packed {
      logic                         wr_vec;
      logic                         wr_qry;
      action_type                   act;
      logic [ENTRY_MAX_W-1:0]       entry;
      logic [COUNT_MAX_W-1:0]       count;
      logic [COMP_W-1:0]            comp;
      logic signed [COORD_BITS-1:0] coord;
   } op_type;

endpackage

### hw/rtl/exhaustive_knn_search_unit.sv
// top level of the knn search unit: register port, front, queues, back
// depends on eknn_pkg, eknn_fifo, eknn_front, eknn_back and the defines header
`timescale 1ns / 1ps
`include "exhaustive_knn_search_unit_defines.svh"
// Brute-force k-nearest-neighbour store. Insert and query coordinate beats
// are taken one per clock; the front queues them as operations for the back
// end, so the input stalls only while the operation queue is full. A final
// query beat starts a walk over every stored entry that reads one coordinate
// pair per clock from the vector and query memories, followed by a bit-serial
// square root of ROOT_W bits for each reported neighbour (ROOT_W is 20 with
// the default sizes). Insert, reject and empty-store results are pushed by
// the back end straight from its idle state. The vector memory needs no
// clearing after reset.
module exhaustive_knn_search_unit #(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DIMS    = 128,
   parameter int MAX_K       = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  eknn_pkg::req_type req_item,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output eknn_pkg::rsp_type rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   localparam int DIMW = $clog2(MAX_DIMS + 1);
   localparam int KW   = $clog2(MAX_K + 1);
   localparam int CNTW = $clog2(MAX_ENTRIES + 1);
   localparam int OPW  = $bits(eknn_pkg::op_type);
   localparam int RSPW = $bits(eknn_pkg::rsp_type);

   logic [7:0]        dims_ff;
   logic [4:0]        neigh_ff;
   logic [DIMW-1:0]   dims_eff;
   logic [KW-1:0]     k_eff;
   logic              cfg_wr;

   eknn_pkg::op_type  front_op, back_op;
   eknn_pkg::rsp_type back_rsp;
   logic              op_push, op_full, op_pop, op_empty;
   logic              rsp_push, rsp_full, back_busy;
   logic [CNTW-1:0]   entry_count;
   logic [OPW-1:0]    op_q_data;
   logic [RSPW-1:0]   rsp_q_data;

   // register port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == eknn_pkg::REG_NEIGH) ? {27'd0, neigh_ff} : {24'd0, dims_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= eknn_pkg::DIMS_RESET;
         neigh_ff <= eknn_pkg::NEIGH_RESET;
      end else if (cfg_wr) begin
         case (paddr[2])
            eknn_pkg::REG_DIMS:  dims_ff  <= pwdata[7:0];
            eknn_pkg::REG_NEIGH: neigh_ff <= pwdata[4:0];
            default: begin
            end
         endcase
      end
   end

   // clamp registers to the supported range
   always_comb begin
      if (dims_ff == '0) begin
         dims_eff = DIMW'(1);
      end else if (int'(dims_ff) > MAX_DIMS) begin
         dims_eff = DIMW'(MAX_DIMS);
      end else begin
         dims_eff = DIMW'(dims_ff);
      end
      if (neigh_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(neigh_ff) > MAX_K) begin
         k_eff = KW'(MAX_K);
      end else begin
         k_eff = KW'(neigh_ff);
      end
   end

   eknn_front #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_DIMS    (MAX_DIMS),
      .DIMW        (DIMW),
      .CNTW        (CNTW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (push),
      .req_data    (req_item),
      .req_full    (full),
      .dims        (dims_eff),
      .op_push     (op_push),
      .op          (front_op),
      .op_full     (op_full),
      .entry_count (entry_count)
   );

   // operation queue between front and back
   eknn_fifo #(
      .WIDTH (OPW),
      .DEPTH (4)
   ) u_op_q (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (front_op),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (op_q_data),
      .empty     (op_empty)
   );

   assign back_op = eknn_pkg::op_type'(op_q_data);

   eknn_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_DIMS    (MAX_DIMS),
      .MAX_K       (MAX_K),
      .DIMW        (DIMW),
      .KW          (KW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .dims     (dims_eff),
      .k        (k_eff),
      .op_empty (op_empty),
      .op       (back_op),
      .op_pop   (op_pop),
      .rsp_push (rsp_push),
      .rsp      (back_rsp),
      .rsp_full (rsp_full),
      .busy     (back_busy)
   );

   // result queue
   eknn_fifo #(
      .WIDTH (RSPW),
      .DEPTH (2)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_q_data),
      .empty     (empty)
   );

   assign rsp_item = eknn_pkg::rsp_type'(rsp_q_data);

   // checks
   `EKNN_ASSERT_ALWAYS(a_count_bound, clock, reset, int'(entry_count) <= MAX_ENTRIES)
   `EKNN_ASSERT_IMPLIES(a_no_pop_busy, clock, reset, back_busy, !op_pop)
   `EKNN_ASSERT_RAW(a_empty_after_reset, clock, $past(reset) && !reset, empty)

endmodule

### hw/rtl/eknn_fifo.sv
// small register fifo used for the operation and result queues
// no dependencies
`timescale 1ns / 1ps
module eknn_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (int'(count_ff) == DEPTH);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/eknn_front.sv
// front end: accepts beats, tracks the entry count, turns beats into operations
// depends on eknn_pkg
`timescale 1ns / 1ps
module eknn_front #(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DIMS    = 128,
   parameter int DIMW        = 8,
   parameter int CNTW        = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  eknn_pkg::req_type  req_data,
   output logic               req_full,
   input  logic [DIMW-1:0]    dims,
   output logic               op_push,
   output eknn_pkg::op_type   op,
   input  logic               op_full,
   output logic [CNTW-1:0]    entry_count
);
   logic [CNTW-1:0] entry_count_ff, entry_count_in;
   logic            accept, commit, in_range, store_full, useful;

   assign accept      = req_push && !op_full;
   assign req_full    = op_full;
   assign entry_count = entry_count_ff;

   assign commit     = (int'(req_data.component) == int'(dims) - 1);
   assign in_range   = (int'(req_data.component) < MAX_DIMS);
   assign store_full = (int'(entry_count_ff) >= MAX_ENTRIES);

   // classify the beat
   always_comb begin
      op        = '0;
      op.act    = eknn_pkg::ACT_NONE;
      op.entry  = eknn_pkg::ENTRY_MAX_W'(entry_count_ff);
      op.count  = eknn_pkg::COUNT_MAX_W'(entry_count_ff);
      op.comp   = req_data.component;
      op.coord  = req_data.coordinate;
      entry_count_in = entry_count_ff;
      case (req_data.command)
         eknn_pkg::CMD_INSERT: begin
            op.wr_vec = !store_full && in_range;
            if (commit) begin
               if (store_full) begin
                  op.act = eknn_pkg::ACT_INS_FULL;
               end else begin
                  op.act = eknn_pkg::ACT_INS_OK;
                  entry_count_in = entry_count_ff + 1'b1;
               end
            end
         end
         eknn_pkg::CMD_QUERY: begin
            op.wr_qry = in_range;
            if (commit) begin
               op.act = (entry_count_ff == '0) ? eknn_pkg::ACT_QRY_EMPTY
                                               : eknn_pkg::ACT_QUERY;
            end
         end
         eknn_pkg::CMD_CLEAR: begin
            entry_count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign useful  = op.wr_vec || op.wr_qry || (op.act != eknn_pkg::ACT_NONE);
   assign op_push = accept && useful;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (accept) begin
         entry_count_ff <= entry_count_in;
      end
   end

endmodule

### hw/rtl/eknn_back.sv
// back end: vector and query memories, distance walk, top-k list, square root
// depends on eknn_pkg
`timescale 1ns / 1ps
module eknn_back #(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DIMS    = 128,
   parameter int MAX_K       = 16,
   parameter int DIMW        = 8,
   parameter int KW          = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [DIMW-1:0]    dims,
   input  logic [KW-1:0]      k,
   input  logic               op_empty,
   input  eknn_pkg::op_type   op,
   output logic               op_pop,
   output logic               rsp_push,
   output eknn_pkg::rsp_type  rsp,
   input  logic               rsp_full,
   output logic               busy
);
   localparam int CB      = eknn_pkg::COORD_BITS;
   localparam int CI_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int ENTRY_W = $clog2(MAX_ENTRIES);
   localparam int CNTW    = $clog2(MAX_ENTRIES + 1);
   localparam int VDEPTH  = MAX_ENTRIES * (2 ** CI_W);
   localparam int SQ_W    = 2 * CB;
   localparam int ACC_W   = SQ_W + DIMW;
   localparam int ROOT_W  = (ACC_W + 1) / 2;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 3;
   localparam int SW      = $clog2(ROOT_W + 1);
   localparam int O_W     = (MAX_K > 1) ? $clog2(MAX_K) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_WALK, S_DRAIN, S_LOAD, S_ROOT, S_EMIT
   } state_type;

   typedef struct packed {
      logic               v;
      logic               first;
      logic               last;
      logic               final_e;
      logic [ENTRY_W-1:0] e;
   } tag_type;

   state_type state_ff;

   // memories
   logic signed [CB-1:0] vec_mem [VDEPTH];
   logic signed [CB-1:0] qry_mem [2 ** CI_W];
   logic signed [CB-1:0] vec_rd_ff, qry_rd_ff;

   // walk counters
   logic [ENTRY_W-1:0] walk_e_ff;
   logic [CI_W-1:0]    walk_c_ff;
   logic [CNTW-1:0]    walk_n_ff;
   logic               last_c, last_e, issue;

   // distance pipeline
   tag_type              tag1_ff, tag2_ff, tag3_ff, issue_tag;
   logic signed [CB:0]   diff;
   logic [CB-1:0]        mag_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic                 d_v_ff, d_final_ff;
   logic [ACC_W-1:0]     d_ff;
   logic [ENTRY_W-1:0]   de_ff;

   // top-k list
   logic [ACC_W-1:0]   best_d_ff [MAX_K];
   logic [ENTRY_W-1:0] best_e_ff [MAX_K];
   logic [KW-1:0]      n_ff;
   logic [MAX_K-1:0]   lt, prev_lt;

   // square root and report
   logic [O_W-1:0]    o_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff;
   logic [SW-1:0]     step_ff;
   logic              o_last, needs_out;

   assign busy = (state_ff != S_IDLE);

   // operation pop from the queue
   assign needs_out = (op.act == eknn_pkg::ACT_INS_OK) || (op.act == eknn_pkg::ACT_INS_FULL)
                   || (op.act == eknn_pkg::ACT_QRY_EMPTY);
   assign op_pop    = (state_ff == S_IDLE) && !op_empty && !(needs_out && rsp_full);

   assign o_last = (int'(o_ff) == int'(n_ff) - 1);

   // result beat
   always_comb begin
      rsp      = '0;
      rsp_push = 1'b0;
      if (state_ff == S_IDLE) begin
         rsp.last = 1'b1;
         rsp_push = op_pop && needs_out;
         case (op.act)
            eknn_pkg::ACT_INS_OK: begin
               rsp.status      = eknn_pkg::ST_INS_OK;
               rsp.entry_index = eknn_pkg::INDEX_W'(op.entry);
            end
            eknn_pkg::ACT_INS_FULL: rsp.status = eknn_pkg::ST_INS_FULL;
            default:                rsp.status = eknn_pkg::ST_EMPTY;
         endcase
      end else if (state_ff == S_EMIT) begin
         rsp_push        = !rsp_full;
         rsp.status      = eknn_pkg::ST_NEIGHBOUR;
         rsp.rank        = eknn_pkg::RANK_W'(o_ff);
         rsp.entry_index = eknn_pkg::INDEX_W'(best_e_ff[o_ff]);
         rsp.distance    = eknn_pkg::DIST_W'(root_ff);
         rsp.last        = o_last;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (op_pop && op.wr_vec) begin
         vec_mem[{op.entry[ENTRY_W-1:0], CI_W'(op.comp)}] <= op.coord;
      end
      if (op_pop && op.wr_qry) begin
         qry_mem[CI_W'(op.comp)] <= op.coord;
      end
      vec_rd_ff <= vec_mem[{walk_e_ff, walk_c_ff}];
      qry_rd_ff <= qry_mem[walk_c_ff];
   end

   assign issue  = (state_ff == S_WALK);
   assign last_c = (int'(walk_c_ff) == int'(dims) - 1);
   assign last_e = (int'(walk_e_ff) == int'(walk_n_ff) - 1);

   always_comb begin
      issue_tag.v       = issue;
      issue_tag.first   = (walk_c_ff == '0);
      issue_tag.last    = last_c;
      issue_tag.final_e = last_c && last_e;
      issue_tag.e       = walk_e_ff;
   end

   // difference, square, accumulate
   assign diff   = (CB + 1)'(qry_rd_ff) - (CB + 1)'(vec_rd_ff);
   assign acc_in = (tag3_ff.first ? '0 : acc_ff) + ACC_W'(sq_ff);

   always_ff @(posedge clock) begin
      mag_ff <= diff[CB] ? CB'(-diff) : CB'(diff);
      sq_ff  <= SQ_W'(mag_ff) * SQ_W'(mag_ff);
      if (tag3_ff.v) begin
         acc_ff <= acc_in;
      end
      d_ff       <= acc_in;
      de_ff      <= tag3_ff.e;
      d_final_ff <= tag3_ff.final_e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         d_v_ff  <= 1'b0;
      end else begin
         tag1_ff <= issue_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         d_v_ff  <= tag3_ff.v && tag3_ff.last;
      end
   end

   // compare the new distance against every list slot
   always_comb begin
      for (int i = 0; i < MAX_K; i++) begin
         lt[i] = (i < int'(n_ff)) && (d_ff < best_d_ff[i]);
      end
      prev_lt[0] = 1'b0;
      for (int i = 1; i < MAX_K; i++) begin
         prev_lt[i] = lt[i-1];
      end
   end

   // sorted insertion, later equals stay behind
   always_ff @(posedge clock) begin
      if (d_v_ff) begin
         for (int i = 1; i < MAX_K; i++) begin
            if (i < int'(k) && prev_lt[i]) begin
               best_d_ff[i] <= best_d_ff[i-1];
               best_e_ff[i] <= best_e_ff[i-1];
            end
         end
         for (int i = 0; i < MAX_K; i++) begin
            if (i < int'(k) && !prev_lt[i] && (lt[i] || i == int'(n_ff))) begin
               best_d_ff[i] <= d_ff;
               best_e_ff[i] <= de_ff;
            end
         end
      end
   end

   // square root step, one result bit a cycle
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         walk_e_ff <= '0;
         walk_c_ff <= '0;
         walk_n_ff <= '0;
         n_ff      <= '0;
         o_ff      <= '0;
         step_ff   <= '0;
      end else begin
         if (d_v_ff && int'(n_ff) < int'(k)) begin
            n_ff <= n_ff + 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (op_pop && op.act == eknn_pkg::ACT_QUERY) begin
                  walk_n_ff <= CNTW'(op.count);
                  walk_e_ff <= '0;
                  walk_c_ff <= '0;
                  n_ff      <= '0;
                  state_ff  <= S_WALK;
               end
            end
            S_WALK: begin
               if (last_c) begin
                  walk_c_ff <= '0;
                  if (last_e) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     walk_e_ff <= walk_e_ff + 1'b1;
                  end
               end else begin
                  walk_c_ff <= walk_c_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               if (d_v_ff && d_final_ff) begin
                  o_ff     <= '0;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               rad_ff   <= RAD_W'(best_d_ff[o_ff]);
               rem_ff   <= '0;
               root_ff  <= '0;
               step_ff  <= '0;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               rad_ff <= rad_ff << 2;
               if (rem_sh >= trial) begin
                  rem_ff  <= rem_sh - trial;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (int'(step_ff) == ROOT_W - 1) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!rsp_full) begin
                  if (o_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     o_ff     <= o_ff + 1'b1;
                     state_ff <= S_LOAD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
